FILE: rtl/spq_pkg.sv
// Shared constants, codes and types of the strict-priority four-class queue.
package spq_pkg;

   // Queue geometry.
   localparam int QUEUE_DEPTH = 16;
   localparam int TAG_WIDTH   = 8;
   localparam int NUM_CLASSES = 4;

   // Fixed field widths of the request and response channels.
   localparam int CLASS_W  = 2;
   localparam int TAG_IN_W = 8;
   localparam int TOTAL_W  = 7;

   // Derived widths.
   localparam int STORE_W = (TAG_WIDTH < TAG_IN_W) ? TAG_WIDTH : TAG_IN_W;
   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int CIDX_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int SLOTS   = NUM_CLASSES * QUEUE_DEPTH;
   localparam int ADDR_W  = $clog2(SLOTS);

   // Request command codes.
   typedef enum logic [0:0] {
      CMD_ENQUEUE = 1'b0,
      CMD_DEQUEUE = 1'b1
   } command_type;

   // One registered request.
   typedef struct packed {
      command_type         command;
      logic [CLASS_W-1:0]  priority_class;
      logic [TAG_IN_W-1:0] task_tag;
   } request_type;

   // Response fields that do not come from the tag store.
   typedef struct packed {
      logic               task_valid;
      logic [CLASS_W-1:0] class_out;
      logic               enqueue_refused;
      logic [TOTAL_W-1:0] total_waiting;
   } result_type;

   // Tag store write and read controls.
   typedef struct packed {
      logic               wr_en;
      logic [ADDR_W-1:0]  wr_addr;
      logic [STORE_W-1:0] wr_data;
      logic               rd_en;
      logic [ADDR_W-1:0]  rd_addr;
   } store_ctl_type;

endpackage

FILE: rtl/spq_req_if.sv
// Request channel: valid/ready handshake with the enqueue or dequeue command.
interface spq_req_if;
   logic                         valid;
   logic                         ready;
   logic                         command;
   logic [spq_pkg::CLASS_W-1:0]  priority_class;
   logic [spq_pkg::TAG_IN_W-1:0] task_tag;

   modport source (output valid, output command, output priority_class, output task_tag,
                   input ready);
   modport sink   (input valid, input command, input priority_class, input task_tag,
                   output ready);
endinterface

FILE: rtl/spq_rsp_if.sv
// Response channel: valid/ready handshake with the scheduling result.
interface spq_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         task_valid;
   logic [spq_pkg::TAG_IN_W-1:0] task_out;
   logic [spq_pkg::CLASS_W-1:0]  class_out;
   logic                         enqueue_refused;
   logic [spq_pkg::TOTAL_W-1:0]  total_waiting;

   modport source (output valid, output task_valid, output task_out, output class_out,
                   output enqueue_refused, output total_waiting, input ready);
   modport sink   (input valid, input task_valid, input task_out, input class_out,
                   input enqueue_refused, input total_waiting, output ready);
endinterface

FILE: rtl/strict_priority_four_class_queue.sv
// Strict-priority four-class task queue with a per-class FIFO in a shared tag RAM.
// A request is held in the request register, then its result in the response register.
// Throughput: one request per cycle while the response channel is ready; the
// bookkeeping stage and the tag RAM port each handle one request a cycle.
// Reset: synchronous, active high; clears all pointers, counts and valid flags.
// The tag RAM is not cleared; only entries that were written are ever read.
module strict_priority_four_class_queue (
   input logic        clock,
   input logic        reset,
   spq_req_if.sink    req_bus,
   spq_rsp_if.source  rsp_bus
);

   logic                          a_valid_ff;
   logic                          a_valid_in;
   spq_pkg::request_type          a_req_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   spq_pkg::result_type           res_ff;
   spq_pkg::result_type           res_in;
   spq_pkg::store_ctl_type        store_ctl;
   logic [spq_pkg::STORE_W-1:0]   rd_data;
   logic [spq_pkg::TAG_IN_W-1:0]  tag_wide;
   logic                          out_open;
   logic                          a_fire;
   logic                          req_fire;

   // Pipeline handshake: the request stage moves when the response register frees up.
   always_comb begin
      out_open      = !rsp_valid_ff || rsp_bus.ready;
      a_fire        = a_valid_ff && out_open;
      req_bus.ready = !a_valid_ff || out_open;
      req_fire      = req_bus.valid && req_bus.ready;
      a_valid_in    = req_fire ? 1'b1 : (a_fire ? 1'b0 : a_valid_ff);
      rsp_valid_in  = a_fire ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
   end

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_req_ff.command        <= spq_pkg::command_type'(req_bus.command);
         a_req_ff.priority_class <= req_bus.priority_class;
         a_req_ff.task_tag       <= req_bus.task_tag;
      end
   end

   // Queue bookkeeping and priority selection.
   spq_sched u_sched (
      .clock     (clock),
      .reset     (reset),
      .fire      (a_fire),
      .req       (a_req_ff),
      .store_ctl (store_ctl),
      .result    (res_in)
   );

   // Tag store for all class queues.
   spq_ram #(
      .WIDTH (spq_pkg::STORE_W),
      .DEPTH (spq_pkg::SLOTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_ctl.wr_en),
      .wr_addr (store_ctl.wr_addr),
      .wr_data (store_ctl.wr_data),
      .rd_en   (store_ctl.rd_en),
      .rd_addr (store_ctl.rd_addr),
      .rd_data (rd_data)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_fire) begin
         res_ff <= res_in;
      end
   end

   // The read data holds while the response waits; it is zero unless a task came out.
   always_comb begin
      tag_wide = '0;
      if (res_ff.task_valid) begin
         tag_wide[spq_pkg::STORE_W-1:0] = rd_data;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.task_valid      = res_ff.task_valid;
   assign rsp_bus.task_out        = tag_wide;
   assign rsp_bus.class_out       = res_ff.class_out;
   assign rsp_bus.enqueue_refused = res_ff.enqueue_refused;
   assign rsp_bus.total_waiting   = res_ff.total_waiting;

`ifndef SYNTHESIS
   // No response is pending in the cycle after reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("response valid after reset");

   // A dequeue that sees waiting tasks must return one.
   a_deq_returns: assert property (@(posedge clock) disable iff (reset)
      (a_fire && a_req_ff.command == spq_pkg::CMD_DEQUEUE && res_in.total_waiting
       != {spq_pkg::TOTAL_W{1'b1}} && store_ctl.rd_en)
      |=> (rsp_valid_ff && rsp_bus.task_valid))
      else $error("dequeue with waiting tasks returned nothing");

   // A returned task and a refusal never appear in the same response.
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_bus.task_valid && rsp_bus.enqueue_refused))
      else $error("task returned and enqueue refused together");

   // A store write comes only from an accepted enqueue, a read only from a dequeue.
   a_store_ctl: assert property (@(posedge clock) disable iff (reset)
      (store_ctl.wr_en || store_ctl.rd_en) |-> (a_fire && !(store_ctl.wr_en && store_ctl.rd_en)))
      else $error("tag store access without an accepted request");
`endif

endmodule

FILE: rtl/spq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/spq_sched.sv
// Queue bookkeeping: per-class pointers and counts, priority pick and store access.
module spq_sched (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  spq_pkg::request_type   req,
   output spq_pkg::store_ctl_type store_ctl,
   output spq_pkg::result_type    result
);

   logic [spq_pkg::PTR_W-1:0]   head_ff  [spq_pkg::NUM_CLASSES];
   logic [spq_pkg::PTR_W-1:0]   head_in  [spq_pkg::NUM_CLASSES];
   logic [spq_pkg::PTR_W-1:0]   tail_ff  [spq_pkg::NUM_CLASSES];
   logic [spq_pkg::PTR_W-1:0]   tail_in  [spq_pkg::NUM_CLASSES];
   logic [spq_pkg::CNT_W-1:0]   count_ff [spq_pkg::NUM_CLASSES];
   logic [spq_pkg::CNT_W-1:0]   count_in [spq_pkg::NUM_CLASSES];
   logic [spq_pkg::TOTAL_W-1:0] total_ff;
   logic [spq_pkg::TOTAL_W-1:0] total_in;

   logic [spq_pkg::NUM_CLASSES-1:0] full;
   logic [spq_pkg::NUM_CLASSES-1:0] busy;
   logic [spq_pkg::CIDX_W-1:0]      cls_idx;
   logic [spq_pkg::CIDX_W-1:0]      sel;
   logic                            cls_ok;
   logic                            is_enq;
   logic                            found;
   logic                            enq_ok;
   logic                            deq_ok;
   logic                            enq_hit;
   logic                            deq_hit;

   // Next slot with wrap at the end of a class region.
   function automatic logic [spq_pkg::PTR_W-1:0] advance(input logic [spq_pkg::PTR_W-1:0] ptr);
      logic [spq_pkg::PTR_W-1:0] nxt;
      nxt = ptr + 1'b1;
      if (ptr == spq_pkg::PTR_W'(spq_pkg::QUEUE_DEPTH - 1)) begin
         nxt = '0;
      end
      return nxt;
   endfunction

   // Per-class status flags, each from its own count.
   always_comb begin
      for (int c = 0; c < spq_pkg::NUM_CLASSES; c++) begin
         full[c] = (count_ff[c] == spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH));
         busy[c] = (count_ff[c] != '0);
      end
   end

   // Highest-priority non-empty class: the lowest index wins.
   always_comb begin
      sel   = '0;
      found = 1'b0;
      for (int c = spq_pkg::NUM_CLASSES - 1; c >= 0; c--) begin
         if (busy[c]) begin
            sel   = spq_pkg::CIDX_W'(c);
            found = 1'b1;
         end
      end
   end

   // Decide what this request does.
   always_comb begin
      is_enq  = (req.command == spq_pkg::CMD_ENQUEUE);
      cls_ok  = (32'(req.priority_class) < spq_pkg::NUM_CLASSES);
      cls_idx = spq_pkg::CIDX_W'(req.priority_class);
      enq_ok  = fire && is_enq && cls_ok && !full[cls_idx];
      deq_ok  = fire && !is_enq && found;
   end

   // Next pointers and counts for every class.
   always_comb begin
      enq_hit = 1'b0;
      deq_hit = 1'b0;
      for (int c = 0; c < spq_pkg::NUM_CLASSES; c++) begin
         enq_hit     = enq_ok && (cls_idx == spq_pkg::CIDX_W'(c));
         deq_hit     = deq_ok && (sel == spq_pkg::CIDX_W'(c));
         count_in[c] = count_ff[c] + spq_pkg::CNT_W'(enq_hit) - spq_pkg::CNT_W'(deq_hit);
         tail_in[c]  = enq_hit ? advance(tail_ff[c]) : tail_ff[c];
         head_in[c]  = deq_hit ? advance(head_ff[c]) : head_ff[c];
      end
      total_in = total_ff + spq_pkg::TOTAL_W'(enq_ok) - spq_pkg::TOTAL_W'(deq_ok);
   end

   // Tag store access: write at the tail on enqueue, read at the head on dequeue.
   always_comb begin
      store_ctl.wr_en   = enq_ok;
      store_ctl.wr_addr = spq_pkg::ADDR_W'(32'(cls_idx) * spq_pkg::QUEUE_DEPTH
                                           + 32'(tail_ff[cls_idx]));
      store_ctl.wr_data = req.task_tag[spq_pkg::STORE_W-1:0];
      store_ctl.rd_en   = deq_ok;
      store_ctl.rd_addr = spq_pkg::ADDR_W'(32'(sel) * spq_pkg::QUEUE_DEPTH
                                           + 32'(head_ff[sel]));
   end

   // Response fields other than the tag.
   always_comb begin
      result.task_valid      = !is_enq && found;
      result.class_out       = (!is_enq && found) ? spq_pkg::CLASS_W'(sel) : '0;
      result.enqueue_refused = is_enq && !(cls_ok && !full[cls_idx]);
      result.total_waiting   = total_in;
   end

   // Bookkeeping registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < spq_pkg::NUM_CLASSES; c++) begin
            head_ff[c]  <= '0;
            tail_ff[c]  <= '0;
            count_ff[c] <= '0;
         end
         total_ff <= '0;
      end else begin
         for (int c = 0; c < spq_pkg::NUM_CLASSES; c++) begin
            head_ff[c]  <= head_in[c];
            tail_ff[c]  <= tail_in[c];
            count_ff[c] <= count_in[c];
         end
         total_ff <= total_in;
      end
   end

endmodule

FILE: tb/sv/strict_priority_four_class_queue_tb.sv
// Self-checking testbench for the strict-priority four-class task queue.
`timescale 1ns / 100ps

module strict_priority_four_class_queue_tb;
   import spq_pkg::*;

   // Run shape.
   localparam int unsigned RANDOM_PER_PHASE = 240;
   localparam int unsigned RSP_HOLD_CYCLES  = 120;
   localparam int unsigned STALL_LIMIT      = 2000;
   localparam int unsigned DRAIN_CYCLES     = 8;
   localparam int unsigned REPORT_LIMIT     = 10;
   localparam int          DIRECTED_ROWS    = 14;

   // One response as the scheduler should report it.
   typedef struct packed {
      logic                task_valid;
      logic [TAG_IN_W-1:0] task_out;
      logic [CLASS_W-1:0]  class_out;
      logic                enqueue_refused;
      logic [TOTAL_W-1:0]  total_waiting;
   } schedule_result_type;

   // One row of the directed table; a row may repeat with an incrementing tag.
   typedef struct {
      command_type         cmd;
      logic [CLASS_W-1:0]  cls;
      logic [TAG_IN_W-1:0] tag;
      int unsigned         repeats;
      bit                  has_literal;
      schedule_result_type literal;
   } stimulus_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   spq_req_if req_bus ();
   spq_rsp_if rsp_bus ();

   strict_priority_four_class_queue u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Clock generation.
   always #2 clock = ~clock;

   // Scheduler mirror: one ring of tags per class.
   logic [STORE_W-1:0] ready_ring [NUM_CLASSES][QUEUE_DEPTH];
   int unsigned        ring_head  [NUM_CLASSES];
   int unsigned        ring_count [NUM_CLASSES];

   schedule_result_type pending_results [$];

   int unsigned send_idle_pct = 19;
   int unsigned recv_idle_pct = 76;
   bit          hold_requested = 1'b0;
   int unsigned rsp_hold_left = 0;
   int unsigned stall_cycles = 0;

   int unsigned mismatch_count = 0;
   int unsigned checked_count = 0;
   int unsigned enqueue_count = 0;
   int unsigned refused_count = 0;
   int unsigned dequeue_count = 0;
   int unsigned empty_dequeue_count = 0;
   int unsigned peak_waiting = 0;

   schedule_result_type seen_result;
   schedule_result_type want_result;

   // Directed requests. Literal results are given where they are obvious.
   stimulus_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      '{CMD_DEQUEUE, 2'd0, 8'h00, 1,  1'b1, '{1'b0, 8'h00, 2'd0, 1'b0, 7'd0}},
      '{CMD_ENQUEUE, 2'd3, 8'hFF, 1,  1'b1, '{1'b0, 8'h00, 2'd0, 1'b0, 7'd1}},
      '{CMD_ENQUEUE, 2'd0, 8'h00, 1,  1'b1, '{1'b0, 8'h00, 2'd0, 1'b0, 7'd2}},
      '{CMD_ENQUEUE, 2'd1, 8'hA5, 1,  1'b1, '{1'b0, 8'h00, 2'd0, 1'b0, 7'd3}},
      '{CMD_ENQUEUE, 2'd2, 8'h5A, 1,  1'b1, '{1'b0, 8'h00, 2'd0, 1'b0, 7'd4}},
      '{CMD_DEQUEUE, 2'd3, 8'hFF, 1,  1'b1, '{1'b1, 8'h00, 2'd0, 1'b0, 7'd3}},
      '{CMD_DEQUEUE, 2'd0, 8'h00, 1,  1'b1, '{1'b1, 8'hA5, 2'd1, 1'b0, 7'd2}},
      '{CMD_DEQUEUE, 2'd1, 8'h00, 1,  1'b1, '{1'b1, 8'h5A, 2'd2, 1'b0, 7'd1}},
      '{CMD_DEQUEUE, 2'd2, 8'h00, 1,  1'b1, '{1'b1, 8'hFF, 2'd3, 1'b0, 7'd0}},
      '{CMD_DEQUEUE, 2'd0, 8'h00, 1,  1'b1, '{1'b0, 8'h00, 2'd0, 1'b0, 7'd0}},
      // Fill the normal class; its tail pointer wraps on the way.
      '{CMD_ENQUEUE, 2'd2, 8'h10, 16, 1'b0, '{1'b0, 8'h00, 2'd0, 1'b0, 7'd0}},
      '{CMD_ENQUEUE, 2'd2, 8'h77, 1,  1'b1, '{1'b0, 8'h00, 2'd0, 1'b1, 7'd16}},
      '{CMD_ENQUEUE, 2'd1, 8'h3C, 1,  1'b1, '{1'b0, 8'h00, 2'd0, 1'b0, 7'd17}},
      '{CMD_DEQUEUE, 2'd3, 8'hC3, 1,  1'b1, '{1'b1, 8'h3C, 2'd1, 1'b0, 7'd16}}
   };

   // Works out the response to one request and updates the mirror.
   function automatic schedule_result_type predict_schedule(input request_type r);
      schedule_result_type res;
      int unsigned         c;
      int unsigned         sum;
      res = '0;
      if (r.command == CMD_ENQUEUE) begin
         c = r.priority_class;
         if (c >= NUM_CLASSES || ring_count[c] >= QUEUE_DEPTH) begin
            res.enqueue_refused = 1'b1;
         end else begin
            ready_ring[c][(ring_head[c] + ring_count[c]) % QUEUE_DEPTH] =
               r.task_tag[STORE_W-1:0];
            ring_count[c]++;
         end
      end else begin
         // The lowest-numbered class with a waiting task wins.
         for (c = 0; c < NUM_CLASSES; c++) begin
            if (ring_count[c] != 0) begin
               res.task_valid = 1'b1;
               res.task_out   = TAG_IN_W'(ready_ring[c][ring_head[c]]);
               res.class_out  = CLASS_W'(c);
               ring_head[c]   = (ring_head[c] + 1) % QUEUE_DEPTH;
               ring_count[c]--;
               break;
            end
         end
      end
      sum = 0;
      for (c = 0; c < NUM_CLASSES; c++) begin
         sum += ring_count[c];
      end
      res.total_waiting = TOTAL_W'(sum);
      return res;
   endfunction

   // Offers one request after random idle cycles and records its expected response.
   task automatic offer_request(input request_type r, input bit use_literal,
                                input schedule_result_type literal);
      schedule_result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.command        <= r.command;
      req_bus.priority_class <= r.priority_class;
      req_bus.task_tag       <= r.task_tag;
      do @(posedge clock); while (!req_bus.ready);
      predicted = predict_schedule(r);
      pending_results.push_back(use_literal ? literal : predicted);
      // Bookkeeping for the closing summary.
      if (r.command == CMD_ENQUEUE) begin
         enqueue_count++;
         if (predicted.enqueue_refused) refused_count++;
      end else begin
         dequeue_count++;
         if (!predicted.task_valid) empty_dequeue_count++;
      end
      if (predicted.total_waiting > peak_waiting) peak_waiting = predicted.total_waiting;
      @(negedge clock);
   endtask

   // Random bursts: each burst picks an enqueue bias and a band of classes, so
   // queues both run full and drain empty.
   task automatic run_random_phase(input int unsigned n_items);
      int unsigned         left;
      int unsigned         burst;
      int unsigned         enq_pct;
      int unsigned         lo;
      int unsigned         hi;
      request_type         r;
      left = n_items;
      while (left != 0) begin
         burst = $urandom_range(48, 12);
         if (burst > left) burst = left;
         case ($urandom_range(2))
            0: begin
               enq_pct = 20;
            end
            1: begin
               enq_pct = 50;
            end
            default: begin
               enq_pct = 85;
            end
         endcase
         lo = $urandom_range(NUM_CLASSES - 1);
         hi = $urandom_range(NUM_CLASSES - 1, lo);
         repeat (burst) begin
            r.command        = ($urandom_range(99) < enq_pct) ? CMD_ENQUEUE : CMD_DEQUEUE;
            r.priority_class = CLASS_W'($urandom_range(hi, lo));
            r.task_tag       = TAG_IN_W'($urandom_range(255));
            offer_request(r, 1'b0, '0);
         end
         left -= burst;
      end
   endtask

   // Response side: random stalls, plus one long hold-off when asked for.
   always @(negedge clock) begin
      if (rsp_hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold_left = rsp_hold_left - 1;
      end else if (hold_requested) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold_left = RSP_HOLD_CYCLES - 1;
         hold_requested = 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Response checker: every accepted response against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen_result.task_valid      = rsp_bus.task_valid;
         seen_result.task_out        = rsp_bus.task_out;
         seen_result.class_out       = rsp_bus.class_out;
         seen_result.enqueue_refused = rsp_bus.enqueue_refused;
         seen_result.total_waiting   = rsp_bus.total_waiting;
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("%0t: response with no request outstanding: valid=%0b tag=%02h class=%0d refused=%0b total=%0d",
                        $realtime, seen_result.task_valid, seen_result.task_out,
                        seen_result.class_out, seen_result.enqueue_refused,
                        seen_result.total_waiting);
            end
         end else begin
            want_result = pending_results.pop_front();
            checked_count++;
            if (seen_result.task_valid !== want_result.task_valid ||
                seen_result.task_out !== want_result.task_out ||
                seen_result.class_out !== want_result.class_out ||
                seen_result.enqueue_refused !== want_result.enqueue_refused ||
                seen_result.total_waiting !== want_result.total_waiting) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("%0t: response %0d expected valid=%0b tag=%02h class=%0d refused=%0b total=%0d",
                           $realtime, checked_count, want_result.task_valid,
                           want_result.task_out, want_result.class_out,
                           want_result.enqueue_refused, want_result.total_waiting);
                  $display("%0t: response %0d actual   valid=%0b tag=%02h class=%0d refused=%0b total=%0d",
                           $realtime, checked_count, seen_result.task_valid,
                           seen_result.task_out, seen_result.class_out,
                           seen_result.enqueue_refused, seen_result.total_waiting);
               end
            end
         end
      end
   end

   // Watchdog: ends the run when neither channel has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Watchdog: nothing moved for %0d cycles, %0d responses outstanding",
                  STALL_LIMIT, pending_results.size());
         $display("Some tests failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Main sequence.
   initial begin
      request_type r;
      req_bus.valid          = 1'b0;
      req_bus.command        = CMD_ENQUEUE;
      req_bus.priority_class = '0;
      req_bus.task_tag       = '0;
      rsp_bus.ready          = 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         ring_head[c]  = 0;
         ring_count[c] = 0;
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table, under the first idle pattern.
      foreach (directed_rows[i]) begin
         for (int unsigned k = 0; k < directed_rows[i].repeats; k++) begin
            r.command        = directed_rows[i].cmd;
            r.priority_class = directed_rows[i].cls;
            r.task_tag       = directed_rows[i].tag + TAG_IN_W'(k);
            offer_request(r, directed_rows[i].has_literal, directed_rows[i].literal);
         end
      end

      // Sender idles lightly, receiver stalls heavily.
      run_random_phase(RANDOM_PER_PHASE);

      // The other way round.
      send_idle_pct = 76;
      recv_idle_pct = 19;
      run_random_phase(RANDOM_PER_PHASE);

      // Full rate, opening with a long receiver hold-off so the input backs up.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requested = 1'b1;
      run_random_phase(RANDOM_PER_PHASE);

      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d enqueues (%0d refused on a full class) and %0d dequeues (%0d with all queues empty).",
               enqueue_count, refused_count, dequeue_count, empty_dequeue_count);
      $display("Checked %0d responses, peak occupancy %0d of %0d, %0d mismatches.",
               checked_count, peak_waiting, NUM_CLASSES * QUEUE_DEPTH, mismatch_count);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/spq_pkg.sv
rtl/spq_req_if.sv
rtl/spq_rsp_if.sv
rtl/spq_ram.sv
rtl/spq_sched.sv
rtl/strict_priority_four_class_queue.sv
tb/sv/strict_priority_four_class_queue_tb.sv
